// File: hdl/dsf_pkg.sv
// shared types, constants and helpers of the delimiter strip filter
`timescale 1ns / 1ps
`default_nettype none

package dsf_pkg;

   // depth of the byte hold buffer and of one job's byte list
   localparam int HOLD_DEPTH        = 4;
   localparam int HOLD_IDX_W        = $clog2(HOLD_DEPTH);
   localparam int MAX_DELIM_LEN_DEF = 4;
   localparam int QUEUE_DEPTH       = 2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_CHARS  = 2'd0,
      CSR_FIRST_LEN    = 2'd1,
      CSR_SECOND_CHARS = 2'd2,
      CSR_SECOND_LEN   = 2'd3
   } csr_index_type;

   // configuration as seen by the front end
   typedef struct packed {
      logic [31:0] first_chars;
      logic [2:0]  first_len;
      logic [31:0] second_chars;
      logic [2:0]  second_len;
   } cfg_type;

   // one job: the results caused by one accepted byte
   typedef struct packed {
      logic [HOLD_DEPTH-1:0][7:0] data;
      logic [2:0]                 count;
      logic                       marker;
      logic                       eop;
   } job_type;

   // saturate a pattern length to the usable maximum
   function automatic logic [2:0] eff_len(input logic [2:0] len, input logic [2:0] cap);
      return (len > cap) ? cap : len;
   endfunction

   // byte k of a packed pattern, first byte in the low bits
   function automatic logic [7:0] pat_byte(input logic [31:0] chars,
                                           input logic [HOLD_IDX_W-1:0] k);
      logic [4:0] sh;
      sh = {k, 3'b000};
      return chars[sh +: 8];
   endfunction

endpackage

`default_nettype wire

// File: hdl/dsf_front.sv
// front end: pattern matcher, hold buffer and job builder
`timescale 1ns / 1ps
`default_nettype none

module dsf_front #(
   parameter int MAX_DELIM_LEN = dsf_pkg::MAX_DELIM_LEN_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dsf_pkg::cfg_type cfg,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_byte_in,
   input  wire logic             req_last_in,
   input  wire logic             queue_full,
   output logic                  job_push,
   output dsf_pkg::job_type      job
);

   localparam int CAP = (MAX_DELIM_LEN < dsf_pkg::HOLD_DEPTH) ? MAX_DELIM_LEN
                                                              : dsf_pkg::HOLD_DEPTH;
   localparam logic [2:0] CAP_L = 3'(CAP);

   logic [2:0] match_pos_ff, match_pos_in;
   logic [1:0] live_ff, live_in;
   logic [7:0] held_ff [CAP];

   logic       accept;
   logic [2:0] len0, len1;
   logic [dsf_pkg::HOLD_IDX_W-1:0] pos_idx;
   logic       f0, f1, d0, d1;
   logic       done, hold, emit;
   logic [2:0] pos_plus;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign len0      = dsf_pkg::eff_len(cfg.first_len, CAP_L);
   assign len1      = dsf_pkg::eff_len(cfg.second_len, CAP_L);
   assign pos_idx   = match_pos_ff[dsf_pkg::HOLD_IDX_W-1:0];
   assign pos_plus  = match_pos_ff + 3'd1;

   // classify the byte against both patterns
   always_comb begin
      if (match_pos_ff == 3'd0) begin
         f0 = (len0 >= 3'd1) && (dsf_pkg::pat_byte(cfg.first_chars, '0) == req_byte_in);
         f1 = (len1 >= 3'd1) && (dsf_pkg::pat_byte(cfg.second_chars, '0) == req_byte_in);
      end else begin
         f0 = live_ff[0] && (len0 > match_pos_ff)
              && (dsf_pkg::pat_byte(cfg.first_chars, pos_idx) == req_byte_in);
         f1 = live_ff[1] && (len1 > match_pos_ff)
              && (dsf_pkg::pat_byte(cfg.second_chars, pos_idx) == req_byte_in);
      end
      d0   = f0 && (len0 == pos_plus);
      d1   = f1 && (len1 == pos_plus);
      done = d0 || d1;
      hold = !done && (f0 || f1);
      emit = !done && !hold;
   end

   // next match state
   always_comb begin
      match_pos_in = match_pos_ff;
      live_in      = live_ff;
      if (accept) begin
         if (hold && !req_last_in) begin
            match_pos_in = pos_plus;
            live_in      = {f1, f0};
         end else begin
            match_pos_in = 3'd0;
            live_in      = 2'b00;
         end
      end
   end

   // job: held bytes followed by the current byte
   always_comb begin
      for (int k = 0; k < dsf_pkg::HOLD_DEPTH; k++) begin
         if (k < CAP && 3'(k) != match_pos_ff)
            job.data[k] = held_ff[(k < CAP) ? k : 0];
         else
            job.data[k] = req_byte_in;
      end
      job.eop    = req_last_in;
      job.marker = req_last_in && done;
      if (done)
         job.count = req_last_in ? 3'd1 : 3'd0;
      else if (emit || req_last_in)
         job.count = pos_plus;
      else
         job.count = 3'd0;
      if (job.marker)
         job.data[0] = 8'h00;
      job_push = accept && (job.count != 3'd0);
   end

   // match state and hold buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         match_pos_ff <= 3'd0;
         live_ff      <= 2'b00;
      end else begin
         match_pos_ff <= match_pos_in;
         live_ff      <= live_in;
      end
      for (int k = 0; k < CAP; k++) begin
         if (accept && hold && match_pos_ff == 3'(k))
            held_ff[k] <= req_byte_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/dsf_queue.sv
// short job queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module dsf_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dsf_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output dsf_pkg::job_type      head_job
);

   localparam int PTR_W = (dsf_pkg::QUEUE_DEPTH > 1) ? $clog2(dsf_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(dsf_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_L = CNT_W'(dsf_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_L  = PTR_W'(dsf_pkg::QUEUE_DEPTH - 1);

   dsf_pkg::job_type slot_ff [dsf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full       = (count_ff == DEPTH_L);
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == LAST_L) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == LAST_L) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)
            count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push)
            count_ff <= count_ff - 1'b1;
      end
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// File: hdl/dsf_back.sv
// back end: replays each job as single results into the output register
`timescale 1ns / 1ps
`default_nettype none

module dsf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire dsf_pkg::job_type head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_byte_out,
   output logic                  rsp_byte_valid,
   output logic                  rsp_end_of_param,
   output logic                  rsp_run_last
);

   logic [dsf_pkg::HOLD_IDX_W-1:0] idx_ff;
   logic       rsp_valid_ff;
   logic [7:0] byte_ff;
   logic       byte_valid_ff, eop_ff, run_last_ff;
   logic       load, job_end;

   assign load    = (!rsp_valid_ff || rsp_ready) && head_valid;
   assign job_end = ({1'b0, idx_ff} + 3'd1) == head_job.count;
   assign pop     = load && job_end;

   // result index within the current job and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff       <= job_end ? '0 : idx_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         byte_ff       <= head_job.marker ? 8'h00 : head_job.data[idx_ff];
         byte_valid_ff <= !head_job.marker;
         eop_ff        <= head_job.eop && job_end;
         run_last_ff   <= job_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = byte_ff;
   assign rsp_byte_valid   = byte_valid_ff;
   assign rsp_end_of_param = eop_ff;
   assign rsp_run_last     = run_last_ff;

endmodule

`default_nettype wire

// File: hdl/delimiter_strip_filter.sv
// top level of the delimiter strip filter: configuration registers and the three stages
//
// Usage:
//   req_* carries the parameter string one byte per transfer, req_last_in on its final byte.
//   rsp_* gives the kept bytes, one per transfer. rsp_run_last marks the last result that
//   a byte caused, rsp_end_of_param the final result of the string; a string that ends in
//   a complete delimiter closes with a bare end marker (rsp_byte_valid low).
//   csr_* writes the two patterns and their lengths; csr_ready is always high. Write only
//   while no string is in flight.
// A result is registered in the job queue and then in the output register before it shows on rsp_valid.
// Throughput: one byte per cycle while the receiver is ready and each byte yields at most
//   one result; a byte that releases k held bytes yields k+1 results, and the two-entry job
//   queue between matcher and output stage then fills and holds off req_ready.
// Reset clears the match state, the queue and the output register, and loads the default
//   configuration (both patterns one zero byte long).
// When the receiver stalls, the output register holds its result, the queue fills and
//   req_ready drops after two more jobs.
`timescale 1ns / 1ps
`default_nettype none

module delimiter_strip_filter #(
   parameter int MAX_DELIM_LEN = dsf_pkg::MAX_DELIM_LEN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_byte_in,
   input  wire logic                            req_last_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [7:0]                           rsp_byte_out,
   output logic                                 rsp_byte_valid,
   output logic                                 rsp_end_of_param,
   output logic                                 rsp_run_last,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [dsf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                     csr_data
);

   dsf_pkg::cfg_type cfg_ff;
   dsf_pkg::job_type push_job, head_job;
   logic             job_push, queue_full, pop, head_valid;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_chars  <= 32'd0;
         cfg_ff.first_len    <= 3'd1;
         cfg_ff.second_chars <= 32'd0;
         cfg_ff.second_len   <= 3'd1;
      end else if (csr_valid) begin
         unique case (dsf_pkg::csr_index_type'(csr_index))
            dsf_pkg::CSR_FIRST_CHARS:  cfg_ff.first_chars  <= csr_data;
            dsf_pkg::CSR_FIRST_LEN:    cfg_ff.first_len    <= csr_data[2:0];
            dsf_pkg::CSR_SECOND_CHARS: cfg_ff.second_chars <= csr_data;
            dsf_pkg::CSR_SECOND_LEN:   cfg_ff.second_len   <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // matcher
   dsf_front #(.MAX_DELIM_LEN(MAX_DELIM_LEN)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .req_last_in (req_last_in),
      .queue_full  (queue_full),
      .job_push    (job_push),
      .job         (push_job)
   );

   // job queue
   dsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // result replay
   dsf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_end_of_param (rsp_end_of_param),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

`default_nettype wire

// File: tb/tb_delimiter_strip_filter.sv
// self-checking testbench of the delimiter strip filter with a built-in byte predictor
`timescale 1ns / 1ps

module tb_delimiter_strip_filter;

   localparam int IDLE_LIMIT  = 3000;
   localparam int SETTLE_CYC  = 8;
   localparam int PHASE_BYTES = 20;
   localparam int RAND_PHASES = 8;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } in_rec_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       eop;
      logic       run_last;
   } out_rec_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [7:0]                      req_byte_in;
   logic                            req_last_in;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [7:0]                      rsp_byte_out;
   logic                            rsp_byte_valid;
   logic                            rsp_end_of_param;
   logic                            rsp_run_last;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [dsf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [31:0]                     csr_data;

   delimiter_strip_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_end_of_param (rsp_end_of_param),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // pending bytes for the sender, and the kept bytes still awaited
   in_rec_type  byte_q [$];
   out_rec_type kept_q [$];

   // predictor copy of the patterns and the match state
   logic [31:0] pat_chars [2];
   logic [2:0]  pat_len_reg [2];
   logic [7:0]  hold_buf [dsf_pkg::HOLD_DEPTH];
   int          hold_cnt;
   logic [1:0]  alive;

   int          err_count;
   int          results_n;
   int          bytes_queued;
   int          strings_n;
   int          settings_n;
   int          idle_cycles;
   int          burst_left;
   int          gap_left;
   logic        req_taken;
   bit          sender_gaps;
   bit          rsp_stalls;
   logic [15:0] stall_pat;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [2:0] usable_len(input int j);
      return (pat_len_reg[j] > 3'd4) ? 3'd4 : pat_len_reg[j];
   endfunction

   function automatic logic [7:0] pat_at(input int j, input int k);
      return pat_chars[j][8*(k%4) +: 8];
   endfunction

   function automatic void keep_byte(input logic [7:0] data, input logic valid);
      out_rec_type r;
      r.data     = data;
      r.valid    = valid;
      r.eop      = 1'b0;
      r.run_last = 1'b0;
      kept_q.push_back(r);
   endfunction

   // advance the predicted match state by one byte and queue what it releases
   function automatic void strip_step(input logic [7:0] b, input logic last);
      out_rec_type r;
      logic [1:0]  starts;
      bit          hit;
      bit          done;
      int          pos;
      int          first;
      first  = kept_q.size();
      starts = 2'b00;
      hit    = 1'b0;
      done   = 1'b0;
      if (hold_cnt == 0) begin
         // a fresh candidate replaces the live set outright
         for (int j = 0; j < 2; j++)
            if (usable_len(j) >= 1 && pat_at(j, 0) == b) begin
               starts[j] = 1'b1;
               if (usable_len(j) == 1) done = 1'b1;
            end
         if (done) begin
            alive = 2'b00;
         end else if (starts != 2'b00) begin
            alive       = starts;
            hold_buf[0] = b;
            hold_cnt    = 1;
         end else begin
            alive = 2'b00;
            keep_byte(b, 1'b1);
         end
      end else begin
         pos = hold_cnt;
         // lower pattern wins when both complete on this byte
         for (int j = 0; j < 2 && !done; j++)
            if (alive[j]) begin
               if (usable_len(j) > pos && pat_at(j, pos) == b) begin
                  hit = 1'b1;
                  if (usable_len(j) == pos + 1) done = 1'b1;
               end else begin
                  alive[j] = 1'b0;
               end
            end
         if (done) begin
            hold_cnt = 0;
            alive    = 2'b00;
         end else if (hit) begin
            hold_buf[pos] = b;
            hold_cnt      = pos + 1;
         end else begin
            // broken match: release held bytes and this one, no rescan
            for (int k = 0; k < pos; k++) keep_byte(hold_buf[k], 1'b1);
            keep_byte(b, 1'b1);
            hold_cnt = 0;
            alive    = 2'b00;
         end
      end
      if (last) begin
         for (int k = 0; k < hold_cnt; k++) keep_byte(hold_buf[k], 1'b1);
         hold_cnt = 0;
         alive    = 2'b00;
         if (kept_q.size() == first) keep_byte(8'h00, 1'b0);
         r     = kept_q[kept_q.size()-1];
         r.eop = 1'b1;
         kept_q[kept_q.size()-1] = r;
      end
      if (kept_q.size() > first) begin
         r          = kept_q[kept_q.size()-1];
         r.run_last = 1'b1;
         kept_q[kept_q.size()-1] = r;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch: %s at result %0d, got %0h, expected %0h", what, results_n, got, want);
      err_count++;
   endtask

   // sender: bursts of bytes with random gaps between them
   always @(negedge clock) begin
      in_rec_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0 || byte_q.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            nxt = byte_q.pop_front();
            req_valid   <= 1'b1;
            req_byte_in <= nxt.data;
            req_last_in <= nxt.last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= (sender_gaps && $urandom_range(0, 3) != 0) ?
                             $urandom_range(1, 5) : 0;
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver: stalls follow a rotating pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_pat <= {stall_pat[0], stall_pat[15:1]};
         rsp_ready <= rsp_stalls ? stall_pat[0] : 1'b1;
      end
   end

   // monitor: predict on each byte transfer, check each result transfer, watchdog
   always @(posedge clock) begin
      out_rec_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) strip_step(req_byte_in, req_last_in);
         if (rsp_valid && rsp_ready) begin
            if (kept_q.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_byte_out, 8'h00);
            end else begin
               want = kept_q.pop_front();
               if (rsp_byte_out !== want.data)
                  report_mismatch("byte_out", rsp_byte_out, want.data);
               if (rsp_byte_valid !== want.valid)
                  report_mismatch("byte_valid", {7'd0, rsp_byte_valid}, {7'd0, want.valid});
               if (rsp_end_of_param !== want.eop)
                  report_mismatch("end_of_param", {7'd0, rsp_end_of_param}, {7'd0, want.eop});
               if (rsp_run_last !== want.run_last)
                  report_mismatch("run_last", {7'd0, rsp_run_last}, {7'd0, want.run_last});
            end
            results_n++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results awaited",
                     idle_cycles, kept_q.size());
            $display("tb_delimiter_strip_filter failed");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      in_rec_type it;
      it.data = b;
      it.last = last;
      byte_q.push_back(it);
      bytes_queued++;
   endtask

   // register write, mirrored into the predictor once transferred
   task automatic write_reg(input dsf_pkg::csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         dsf_pkg::CSR_FIRST_CHARS:  pat_chars[0]   = val;
         dsf_pkg::CSR_FIRST_LEN:    pat_len_reg[0] = val[2:0];
         dsf_pkg::CSR_SECOND_CHARS: pat_chars[1]   = val;
         dsf_pkg::CSR_SECOND_LEN:   pat_len_reg[1] = val[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] c0, input logic [2:0] l0,
                             input logic [31:0] c1, input logic [2:0] l1);
      write_reg(dsf_pkg::CSR_FIRST_CHARS, c0);
      write_reg(dsf_pkg::CSR_FIRST_LEN, {29'd0, l0});
      write_reg(dsf_pkg::CSR_SECOND_CHARS, c1);
      write_reg(dsf_pkg::CSR_SECOND_LEN, {29'd0, l1});
      settings_n++;
   endtask

   // hold off until every queued byte is sent and every result has come back
   task automatic drain();
      @(posedge clock);
      while (byte_q.size() != 0 || req_valid) @(posedge clock);
      while (kept_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   function automatic logic [2:0] rand_len();
      return ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
   endfunction

   // one string: mostly whole or partial patterns, some noise
   task automatic queue_string();
      in_rec_type s [$];
      in_rec_type it;
      int         sel;
      int         j;
      int         n;
      logic [2:0] plen;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            it.data = 8'($urandom_range(0, 255));
            it.last = 1'b0;
            s.push_back(it);
         end
      end else begin
         repeat ($urandom_range(1, 6)) begin
            sel     = $urandom_range(0, 99);
            j       = $urandom_range(0, 1);
            plen    = usable_len(j);
            it.last = 1'b0;
            if (sel < 40 && plen != 0) begin
               for (int k = 0; k < plen; k++) begin
                  it.data = pat_at(j, k);
                  s.push_back(it);
               end
            end else if (sel < 65 && plen > 1) begin
               n = $urandom_range(1, plen - 1);
               for (int k = 0; k < n; k++) begin
                  it.data = pat_at(j, k);
                  s.push_back(it);
               end
               if ($urandom_range(0, 1) == 1) begin
                  it.data = 8'($urandom_range(0, 255));
                  s.push_back(it);
               end
            end else if (sel < 85) begin
               it.data = pat_at(j, $urandom_range(0, 3));
               s.push_back(it);
            end else begin
               it.data = 8'($urandom_range(0, 255));
               s.push_back(it);
            end
         end
      end
      foreach (s[i]) push_byte(s[i].data, i == s.size() - 1);
      strings_n++;
   endtask

   // stimulus
   initial begin
      logic [31:0] c0;
      logic [31:0] c1;
      int          start;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_byte_in = 8'h00;
      req_last_in = 1'b0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = 32'h0;
      err_count   = 0;
      results_n   = 0;
      bytes_queued = 0;
      strings_n   = 0;
      settings_n  = 0;
      idle_cycles = 0;
      burst_left  = 0;
      gap_left    = 0;
      sender_gaps = 1'b1;
      rsp_stalls  = 1'b1;
      stall_pat   = 16'hb5a7;
      // predictor reset state: both patterns one zero byte
      pat_chars[0]   = 32'h0;
      pat_chars[1]   = 32'h0;
      pat_len_reg[0] = 3'd1;
      pat_len_reg[1] = 3'd1;
      hold_cnt       = 0;
      alive          = 2'b00;
      foreach (hold_buf[i]) hold_buf[i] = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset patterns: a zero byte vanishes, a string ending in one leaves a bare marker
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b1);
      drain();

      // long and short patterns sharing a first byte; breaks at depths two and three
      set_config(32'h44434241, 3'd4, 32'h00005841, 3'd2);
      push_byte("A", 1'b0); push_byte("B", 1'b0); push_byte("C", 1'b0); push_byte("D", 1'b0);
      push_byte("A", 1'b0); push_byte("X", 1'b0);
      push_byte("A", 1'b0); push_byte("B", 1'b0); push_byte("Z", 1'b0);
      push_byte("A", 1'b0); push_byte("B", 1'b0); push_byte("C", 1'b0); push_byte("Z", 1'b0);
      push_byte("A", 1'b0); push_byte("B", 1'b0); push_byte("C", 1'b1);
      drain();

      // identical patterns completing on the same byte
      set_config(32'h00004241, 3'd2, 32'hffff4241, 3'd2);
      push_byte("A", 1'b0); push_byte("B", 1'b0); push_byte("B", 1'b1);
      drain();

      // disabled second pattern, then the first shrinks under a partial match
      set_config(32'h44434241, 3'd4, 32'h00000041, 3'd0);
      push_byte("A", 1'b0); push_byte("B", 1'b0); push_byte("C", 1'b0);
      drain();
      write_reg(dsf_pkg::CSR_FIRST_LEN, 32'd2);
      push_byte("D", 1'b1);
      drain();

      // random phases, the first two at the register extremes
      for (int p = 0; p < RAND_PHASES; p++) begin
         @(posedge clock);
         sender_gaps = (p % 3) != 2;
         rsp_stalls  = (p % 4) != 3;
         stall_pat   = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom & $urandom);
         stall_pat[0] = 1'b1;
         if (p == 0) begin
            set_config(32'h00000000, 3'd4, 32'hffffffff, 3'd4);
         end else if (p == 1) begin
            set_config(32'hffffffff, 3'd7, 32'h00000000, 3'd0);
         end else begin
            c0 = $urandom;
            c1 = $urandom;
            case ($urandom_range(0, 3))
               0: c1[7:0]  = c0[7:0];
               1: c1[15:0] = c0[15:0];
               default: ;
            endcase
            set_config(c0, rand_len(), c1, rand_len());
         end
         start = bytes_queued;
         while (bytes_queued - start < PHASE_BYTES) queue_string();
         drain();
      end

      if (kept_q.size() != 0)
         report_mismatch("results never delivered", 8'(kept_q.size()), 8'h00);
      $display("run covered %0d bytes in %0d strings under %0d pattern settings",
               bytes_queued, strings_n, settings_n);
      $display("%0d results checked, %0d mismatches", results_n, err_count);
      if (err_count == 0)
         $display("tb_delimiter_strip_filter passed");
      else
         $display("tb_delimiter_strip_filter failed");
      $finish;
   end

endmodule
